// File: rtl/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // geometry of the fixed-point datapath
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned ENTRY_BITS  = 21;
  localparam int unsigned AXES        = 3;
  localparam int unsigned ROW_BITS    = AXES * ENTRY_BITS;
  localparam int unsigned DIFF_BITS   = COORD_BITS + 1;
  localparam int unsigned PROD_BITS   = ENTRY_BITS + DIFF_BITS;
  localparam int unsigned ACC_BITS    = PROD_BITS + 2;
  localparam int unsigned COMP_BITS   = ACC_BITS - COORD_BITS;
  localparam int unsigned SQ_BITS     = 2 * COMP_BITS;
  localparam int unsigned SUM_BITS    = SQ_BITS + 2;
  localparam int unsigned DIST_BITS   = 46;
  localparam int unsigned SHELL_BITS  = 2;
  localparam int unsigned CUTOFF_REGS = 3;
  localparam int unsigned MAX_SHELLS  = 3;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = ROW_BITS;

  localparam logic [AXES-1:0] PERIODIC_RESET = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASIS_ROW_0    = 3'd0,
    REG_BASIS_ROW_1    = 3'd1,
    REG_BASIS_ROW_2    = 3'd2,
    REG_PERIODIC_MASK  = 3'd3,
    REG_CUTOFF_FIRST   = 3'd4,
    REG_CUTOFF_SECOND  = 3'd5,
    REG_CUTOFF_THIRD   = 3'd6,
    REG_ACTIVE_SHELLS  = 3'd7
  } cfg_reg_e;

  typedef logic        [FIELD_BITS-1:0] field_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic        [COMP_BITS-1:0]  mag_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;
  typedef logic        [DIST_BITS-1:0]  dist_t;
  typedef logic        [SHELL_BITS-1:0] shell_t;

  typedef struct packed {
    logic [AXES-1:0][ROW_BITS-1:0]     basis;
    logic [AXES-1:0]                   periodic;
    logic [CUTOFF_REGS-1:0][DIST_BITS-1:0] cutoff;
    shell_t                            active;
  } cfg_t;

  // load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

`default_nettype wire

// File: rtl/periodic_pair_shell_classifier.sv
// pipeline: five register stages; an accepted transaction moves through stages one to five,
// the last of which is the output register
// throughput: one transaction per cycle while the output is not stalled; the five stages each hold one pair
// a stall on the output stops only the stages that are full, so bubbles collapse
// reset: asynchronous, active low; clears all valid bits and loads the register reset values
// (basis and cutoffs zero, all axes periodic, no active shells); payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module periodic_pair_shell_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [psc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // pair input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [15:0]                         site_a_i,
  input  logic [15:0]                         site_b_i,
  input  logic [15:0]                         a_x_i,
  input  logic [15:0]                         a_y_i,
  input  logic [15:0]                         a_z_i,
  input  logic [15:0]                         b_x_i,
  input  logic [15:0]                         b_y_i,
  input  logic [15:0]                         b_z_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          shell_o,
  output logic                                beyond_o,
  output logic [45:0]                         dist_sq_o
);
  import psc_pkg::*;

  cfg_t     cfg;
  pipe_en_t en;

  // one valid bit per stage; stage five is the output register
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d;

  field_t a_c [AXES];
  field_t b_c [AXES];
  diff_t  d [AXES];
  logic   same1, same3;
  mag_t   mag [AXES];

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    en.s5 = !v5_q || !out_stall_i;
    en.s4 = !v4_q || en.s5;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  always_comb begin
    v1_d = en.s1 ? in_valid_i : v1_q;
    v2_d = en.s2 ? v1_q       : v2_q;
    v3_d = en.s3 ? v2_q       : v3_q;
    v4_d = en.s4 ? v3_q       : v4_q;
    v5_d = en.s5 ? v4_q       : v5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
    end
  end

  assign in_stall_o  = !en.s1;
  assign out_valid_o = v5_q;

  assign a_c[0] = a_x_i;
  assign a_c[1] = a_y_i;
  assign a_c[2] = a_z_i;
  assign b_c[0] = b_x_i;
  assign b_c[1] = b_y_i;
  assign b_c[2] = b_z_i;

  psc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // stage 1: same-site check and per-axis difference with optional wrap
  psc_delta u_delta (
    .clk_i      (clk_i),
    .en_i       (en.s1),
    .periodic_i (cfg.periodic),
    .site_a_i   (site_a_i),
    .site_b_i   (site_b_i),
    .a_i        (a_c),
    .b_i        (b_c),
    .d_o        (d),
    .same_o     (same1)
  );

  // stages 2 and 3: basis products, then row sums floored to component magnitudes
  psc_project u_project (
    .clk_i   (clk_i),
    .en_i    (en),
    .basis_i (cfg.basis),
    .d_i     (d),
    .same_i  (same1),
    .mag_o   (mag),
    .same_o  (same3)
  );

  // stages 4 and 5: squares, then the distance sum and shell lookup
  psc_classify u_classify (
    .clk_i     (clk_i),
    .en_i      (en),
    .cfg_i     (cfg),
    .mag_i     (mag),
    .same_i    (same3),
    .shell_o   (shell_o),
    .beyond_o  (beyond_o),
    .dist_sq_o (dist_sq_o)
  );

  // a result is never both inside a shell and beyond
  a_shell_beyond_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(beyond_o && (shell_o != '0)))
    else $error("shell and beyond both set");

  // a reported shell never exceeds the number of active cutoffs
  a_shell_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (shell_o != '0)) |-> (shell_o <= cfg.active))
    else $error("shell beyond active cutoff count");

  // an accepted transaction always occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction lost at stage one");

  // the input side stalls only when every stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: rtl/psc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [psc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  output psc_pkg::cfg_t                       cfg_o
);
  import psc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.basis    <= '0;
      cfg_q.periodic <= PERIODIC_RESET;
      cfg_q.cutoff   <= '0;
      cfg_q.active   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BASIS_ROW_0:   cfg_q.basis[0]  <= ROW_BITS'(cfg_wdata_i);
        REG_BASIS_ROW_1:   cfg_q.basis[1]  <= ROW_BITS'(cfg_wdata_i);
        REG_BASIS_ROW_2:   cfg_q.basis[2]  <= ROW_BITS'(cfg_wdata_i);
        REG_PERIODIC_MASK: cfg_q.periodic  <= cfg_wdata_i[AXES-1:0];
        REG_CUTOFF_FIRST:  cfg_q.cutoff[0] <= cfg_wdata_i[DIST_BITS-1:0];
        REG_CUTOFF_SECOND: cfg_q.cutoff[1] <= cfg_wdata_i[DIST_BITS-1:0];
        REG_CUTOFF_THIRD:  cfg_q.cutoff[2] <= cfg_wdata_i[DIST_BITS-1:0];
        REG_ACTIVE_SHELLS: cfg_q.active    <= cfg_wdata_i[SHELL_BITS-1:0];
        default:           cfg_q           <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/psc_delta.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_delta (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [psc_pkg::AXES-1:0]            periodic_i,
  input  psc_pkg::field_t                     site_a_i,
  input  psc_pkg::field_t                     site_b_i,
  input  psc_pkg::field_t                     a_i [psc_pkg::AXES],
  input  psc_pkg::field_t                     b_i [psc_pkg::AXES],
  output psc_pkg::diff_t                      d_o [psc_pkg::AXES],
  output logic                                same_o
);
  import psc_pkg::*;

  diff_t d_d [AXES];
  diff_t d_q [AXES];
  logic  same_q;

  always_comb begin
    logic [COORD_BITS-1:0] ca;
    logic [COORD_BITS-1:0] cb;
    logic [DIFF_BITS-1:0]  raw;
    for (int j = 0; j < AXES; j++) begin
      ca  = COORD_BITS'(a_i[j]);
      cb  = COORD_BITS'(b_i[j]);
      raw = {1'b0, cb} - {1'b0, ca};
      // minimum image: keep the low bits as a two's complement value
      if (periodic_i[j]) begin
        d_d[j] = {raw[COORD_BITS-1], raw[COORD_BITS-1:0]};
      end else begin
        d_d[j] = raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_d;
      same_q <= (site_a_i == site_b_i);
    end
  end

  assign d_o    = d_q;
  assign same_o = same_q;

endmodule

`default_nettype wire

// File: rtl/psc_project.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_project (
  input  logic                                    clk_i,
  input  psc_pkg::pipe_en_t                       en_i,
  input  logic [psc_pkg::AXES-1:0][psc_pkg::ROW_BITS-1:0] basis_i,
  input  psc_pkg::diff_t                          d_i [psc_pkg::AXES],
  input  logic                                    same_i,
  output psc_pkg::mag_t                           mag_o [psc_pkg::AXES],
  output logic                                    same_o
);
  import psc_pkg::*;

  prod_t prod_d [AXES][AXES];
  prod_t prod_q [AXES][AXES];
  logic  same2_q;
  mag_t  mag_d [AXES];
  mag_t  mag_q [AXES];
  logic  same3_q;

  // stage 2: nine basis-entry by difference products
  always_comb begin
    logic signed [ENTRY_BITS-1:0] e;
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < AXES; j++) begin
        e            = $signed(basis_i[i][ENTRY_BITS*j +: ENTRY_BITS]);
        prod_d[i][j] = PROD_BITS'(e * d_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q  <= prod_d;
      same2_q <= same_i;
    end
  end

  // stage 3: row sums, floor by shift, magnitude
  always_comb begin
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [COMP_BITS-1:0] c;
    for (int i = 0; i < AXES; i++) begin
      acc = ACC_BITS'(prod_q[i][0]) + ACC_BITS'(prod_q[i][1]) + ACC_BITS'(prod_q[i][2]);
      c   = $signed(acc[ACC_BITS-1:COORD_BITS]);
      mag_d[i] = c[COMP_BITS-1] ? mag_t'(~c + 1'b1) : mag_t'(c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mag_q   <= mag_d;
      same3_q <= same2_q;
    end
  end

  assign mag_o  = mag_q;
  assign same_o = same3_q;

endmodule

`default_nettype wire

// File: rtl/psc_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_classify (
  input  logic                 clk_i,
  input  psc_pkg::pipe_en_t    en_i,
  input  psc_pkg::cfg_t        cfg_i,
  input  psc_pkg::mag_t        mag_i [psc_pkg::AXES],
  input  logic                 same_i,
  output psc_pkg::shell_t      shell_o,
  output logic                 beyond_o,
  output psc_pkg::dist_t       dist_sq_o
);
  import psc_pkg::*;

  localparam logic [SUM_BITS-1:0] DistMax = SUM_BITS'({DIST_BITS{1'b1}});

  sq_t    sq_d [AXES];
  sq_t    sq_q [AXES];
  logic   same4_q;
  shell_t shell_d, shell_q;
  logic   beyond_d, beyond_q;
  dist_t  dist_d, dist_q;

  // stage 4: squares of the cartesian components
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sq_d[i] = mag_i[i] * mag_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      sq_q    <= sq_d;
      same4_q <= same_i;
    end
  end

  // stage 5: sum, saturate, first active cutoff strictly above the distance; a same-site pair gives all zeros
  always_comb begin
    logic [SUM_BITS-1:0]   sum;
    logic [SHELL_BITS-1:0] n;
    logic                  hit;
    sum = SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
    if (sum > DistMax) begin
      sum = DistMax;
    end
    n = (cfg_i.active > SHELL_BITS'(MAX_SHELLS)) ? SHELL_BITS'(MAX_SHELLS) : cfg_i.active;
    hit     = 1'b0;
    shell_d = '0;
    for (int i = 0; i < CUTOFF_REGS; i++) begin
      if (!hit && (SHELL_BITS'(i) < n) && (SUM_BITS'(cfg_i.cutoff[i]) > sum)) begin
        hit     = 1'b1;
        shell_d = SHELL_BITS'(i + 1);
      end
    end
    beyond_d = !hit;
    dist_d   = sum[DIST_BITS-1:0];
    if (same4_q) begin
      shell_d  = '0;
      beyond_d = 1'b0;
      dist_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      shell_q  <= shell_d;
      beyond_q <= beyond_d;
      dist_q   <= dist_d;
    end
  end

  assign shell_o   = shell_q;
  assign beyond_o  = beyond_q;
  assign dist_sq_o = dist_q;

endmodule

`default_nettype wire
